/* design/vec3_fixed_point_alu_core_defines.svh */
// Assertion macros for the vec3 fixed-point ALU.
// The top level includes this file.
`ifndef VEC3_FIXED_POINT_ALU_CORE_DEFINES_SVH
`define VEC3_FIXED_POINT_ALU_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Checked while out of reset.
`define VFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every edge, reset included.
`define VFA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define VFA_ASSERT(lbl, prop, msg)
`define VFA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* design/vfa_pkg.sv */
// Shared types, constants and saturation helper for the vec3 fixed-point ALU.
// No dependencies; every module imports this package.
package vfa_pkg;

  localparam int CompW    = 32;
  localparam int FracW    = 16;
  localparam int ProdW    = 2 * CompW;
  localparam int SumW     = ProdW + 2;
  localparam int SqW      = ProdW;
  localparam int RootW    = CompW;
  localparam int DivW     = CompW + FracW;
  localparam int NumLanes = 3;

  // Pipeline stage numbers.
  localparam int StSum       = 1;
  localparam int StSqrtLast  = StSum + RootW;
  localparam int StDivFirst  = StSqrtLast + 1;
  localparam int StDivLast   = StSqrtLast + DivW;
  localparam int NumStages   = StDivLast + 2;

  typedef logic signed [CompW-1:0] comp_t;

  localparam comp_t MaxV = {1'b0, {(CompW-1){1'b1}}};
  localparam comp_t MinV = {1'b1, {(CompW-1){1'b0}}};

  typedef enum logic [3:0] {
    FuncAdd   = 4'd0,
    FuncSub   = 4'd1,
    FuncScale = 4'd2,
    FuncDot   = 4'd3,
    FuncCross = 4'd4,
    FuncLen   = 4'd5,
    FuncNorm  = 4'd6,
    FuncDiv   = 4'd7,
    FuncNeg   = 4'd8
  } func_e;

  typedef struct packed {
    logic [3:0] func;
    comp_t      ax;
    comp_t      ay;
    comp_t      az;
    comp_t      bx;
    comp_t      by;
    comp_t      bz;
    comp_t      scale_factor;
  } in_t;

  typedef struct packed {
    comp_t rx;
    comp_t ry;
    comp_t rz;
    comp_t scalar_result;
    logic  overflow;
    logic  div_zero;
  } out_t;

  typedef struct packed {
    comp_t val;
    logic  ov;
  } sat_t;

  // Item context that travels alongside the arithmetic units.
  typedef struct packed {
    func_e            func;
    comp_t [2:0]      a;
    comp_t            k;
    comp_t [2:0]      r;
    logic             rov;
    comp_t            s;
    logic             sov;
    logic [RootW-1:0] root;
  } ctx_t;

  // Clamp a wide signed value to the component range.
  function automatic sat_t sat_wide(input logic signed [SumW-1:0] v);
    sat_t res;
    res.ov  = !((&v[SumW-1:CompW-1]) || !(|v[SumW-1:CompW-1]));
    res.val = res.ov ? (v[SumW-1] ? MinV : MaxV) : comp_t'(v[CompW-1:0]);
    return res;
  endfunction

endpackage

/* design/vfa_mac_lane.sv */
// One component lane: add/subtract/negate and two multipliers, then a
// combine step for scale and cross. Depends on vfa_pkg.
module vfa_mac_lane (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  vfa_pkg::func_e             func_i,
  input  vfa_pkg::comp_t             a_i,
  input  vfa_pkg::comp_t             b_i,
  input  vfa_pkg::comp_t             x0_i,
  input  vfa_pkg::comp_t             y0_i,
  input  vfa_pkg::comp_t             x1_i,
  input  vfa_pkg::comp_t             y1_i,
  input  vfa_pkg::func_e             func_q_i,
  output logic signed [vfa_pkg::ProdW-1:0] prod_o,
  output vfa_pkg::sat_t              res_o
);
  import vfa_pkg::*;

  logic signed [ProdW-1:0] p0_q, p1_q;
  logic signed [CompW:0]   as_d, as_q;
  logic signed [SumW-1:0]  wide;

  always_comb begin
    unique case (func_i)
      FuncAdd: as_d = (CompW+1)'(a_i) + (CompW+1)'(b_i);
      FuncSub: as_d = (CompW+1)'(a_i) - (CompW+1)'(b_i);
      default: as_d = -(CompW+1)'(a_i);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q <= x0_i * y0_i;
      p1_q <= x1_i * y1_i;
      as_q <= as_d;
    end
  end

  always_comb begin
    unique case (func_q_i)
      FuncAdd, FuncSub, FuncNeg: wide = SumW'(as_q);
      FuncScale:                 wide = SumW'(p0_q >>> FracW);
      FuncCross:                 wide = (SumW'(p0_q) - SumW'(p1_q)) >>> FracW;
      default:                   wide = '0;
    endcase
  end

  assign res_o  = sat_wide(wide);
  assign prod_o = p0_q;

endmodule

/* design/vfa_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
// Depends on vfa_pkg.
module vfa_sqrt (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [vfa_pkg::SqW-1:0]   rad_i,
  output logic [vfa_pkg::RootW-1:0] root_o
);
  import vfa_pkg::*;

  logic [SqW-1:0] n_q   [RootW];
  logic [SqW-1:0] res_q [RootW];

  for (genvar j = 0; j < RootW; j++) begin : g_step
    localparam int Sh = SqW - 2 - 2 * j;
    localparam logic [SqW-1:0] Bit = SqW'(1) << Sh;
    logic [SqW-1:0] n_in, r_in, t;
    if (j == 0) begin : g_first
      assign n_in = rad_i;
      assign r_in = '0;
    end else begin : g_next
      assign n_in = n_q[j-1];
      assign r_in = res_q[j-1];
    end
    assign t = r_in + Bit;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (n_in >= t) begin
          n_q[j]   <= n_in - t;
          res_q[j] <= (r_in >> 1) + Bit;
        end else begin
          n_q[j]   <= n_in;
          res_q[j] <= r_in >> 1;
        end
      end
    end
  end

  assign root_o = res_q[RootW-1][RootW-1:0];

endmodule

/* design/vfa_div_lane.sv */
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on vfa_pkg.
module vfa_div_lane (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [vfa_pkg::DivW-1:0]  dvd_i,
  input  logic [vfa_pkg::CompW-1:0] dvs_i,
  output logic [vfa_pkg::DivW-1:0]  quo_o
);
  import vfa_pkg::*;

  logic [CompW-1:0] rem_q [DivW];
  logic [DivW-1:0]  dq_q  [DivW];
  logic [CompW-1:0] dvs_q [DivW];

  for (genvar j = 0; j < DivW; j++) begin : g_step
    logic [CompW-1:0] rem_in, dvs_in;
    logic [DivW-1:0]  dq_in;
    logic [CompW:0]   sh;
    logic             take;
    if (j == 0) begin : g_first
      assign rem_in = '0;
      assign dq_in  = dvd_i;
      assign dvs_in = dvs_i;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign dq_in  = dq_q[j-1];
      assign dvs_in = dvs_q[j-1];
    end
    assign sh   = {rem_in, dq_in[DivW-1]};
    assign take = sh >= {1'b0, dvs_in};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= take ? CompW'(sh - {1'b0, dvs_in}) : CompW'(sh);
        dq_q[j]  <= {dq_in[DivW-2:0], take};
        dvs_q[j] <= dvs_in;
      end
    end
  end

  assign quo_o = dq_q[DivW-1];

endmodule

/* design/vec3_fixed_point_alu_core.sv */
// Top level of the vec3 fixed-point ALU: lanes, root, dividers and merge.
// Depends on vfa_pkg, vfa_mac_lane, vfa_sqrt, vfa_div_lane and the defines header.
`include "vec3_fixed_point_alu_core_defines.svh"

// The block takes one item per clock while in_stall_o is low and returns each
// result in order. Every item runs the full pipeline whatever its operation:
// a multiply stage, a merge stage that sums the three lane products, a 32-stage
// square root and a 48-stage divider per lane, and an output register. The
// divider is the longest part of the pipeline. A one-entry skid buffer behind
// the output register lets the pipeline take one more item while a finished
// result waits on a stalled consumer.
module vec3_fixed_point_alu_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  vfa_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output vfa_pkg::out_t  out_data_o
);
  import vfa_pkg::*;

  localparam int Last = NumStages - 1;

  logic [NumStages-1:0] v_q;
  logic                 en;
  logic                 skid_full_q;
  out_t                 skid_q, out_q, out_d;

  ctx_t ctx_q [NumStages-1];
  ctx_t ctx_d [NumStages-1];

  comp_t av [NumLanes];
  comp_t bv [NumLanes];

  logic signed [ProdW-1:0] lane_prod [NumLanes];
  sat_t                    lane_res  [NumLanes];

  logic signed [SumW-1:0]  sum;
  sat_t                    dot_sat;
  logic [SqW-1:0]          sq_q;
  logic [RootW-1:0]        root;

  logic [DivW-1:0]         quo [NumLanes];

  // The pipeline moves whenever the skid buffer is free.
  assign en         = !skid_full_q;
  assign in_stall_o = skid_full_q;

  assign av[0] = in_data_i.ax;
  assign av[1] = in_data_i.ay;
  assign av[2] = in_data_i.az;
  assign bv[0] = in_data_i.bx;
  assign bv[1] = in_data_i.by;
  assign bv[2] = in_data_i.bz;

  // Each lane gets the multiplier operands its component needs; the cross
  // product uses the two other components of each vector.
  for (genvar i = 0; i < NumLanes; i++) begin : g_lane
    localparam int J = (i + 1) % NumLanes;
    localparam int L = (i + 2) % NumLanes;
    comp_t x0, y0, x1, y1;
    always_comb begin
      x1 = '0;
      y1 = '0;
      unique case (func_e'(in_data_i.func))
        FuncScale: begin
          x0 = av[i];
          y0 = in_data_i.scale_factor;
        end
        FuncDot: begin
          x0 = av[i];
          y0 = bv[i];
        end
        FuncCross: begin
          x0 = av[J];
          y0 = bv[L];
          x1 = av[L];
          y1 = bv[J];
        end
        FuncLen, FuncNorm: begin
          x0 = av[i];
          y0 = av[i];
        end
        default: begin
          x0 = '0;
          y0 = '0;
        end
      endcase
    end

    vfa_mac_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (en),
      .func_i   (func_e'(in_data_i.func)),
      .a_i      (av[i]),
      .b_i      (bv[i]),
      .x0_i     (x0),
      .y0_i     (y0),
      .x1_i     (x1),
      .y1_i     (y1),
      .func_q_i (ctx_q[0].func),
      .prod_o   (lane_prod[i]),
      .res_o    (lane_res[i])
    );
  end

  // Merge of the lane products: dot product and squared length share it.
  assign sum = SumW'(lane_prod[0]) + SumW'(lane_prod[1]) + SumW'(lane_prod[2]);
  assign dot_sat = sat_wide(sum >>> FracW);

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q <= sum[SqW-1:0];
    end
  end

  vfa_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sq_q),
    .root_o (root)
  );

  // Dividers start once the root is known; divide uses |k| as divisor.
  for (genvar i = 0; i < NumLanes; i++) begin : g_div
    comp_t            a_s;
    logic [CompW-1:0] mag, kmag, dvs;
    assign a_s  = ctx_q[StSqrtLast].a[i];
    assign mag  = a_s[CompW-1] ? CompW'(-a_s) : CompW'(a_s);
    assign kmag = ctx_q[StSqrtLast].k[CompW-1] ? CompW'(-ctx_q[StSqrtLast].k)
                                               : CompW'(ctx_q[StSqrtLast].k);
    assign dvs  = (ctx_q[StSqrtLast].func == FuncNorm) ? root : kmag;

    vfa_div_lane u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .dvd_i ({mag, {FracW{1'b0}}}),
      .dvs_i (dvs),
      .quo_o (quo[i])
    );
  end

  // Item context shifts along with the arithmetic.
  always_comb begin
    ctx_d[0]      = '0;
    ctx_d[0].func = func_e'(in_data_i.func);
    ctx_d[0].a[0] = av[0];
    ctx_d[0].a[1] = av[1];
    ctx_d[0].a[2] = av[2];
    ctx_d[0].k    = in_data_i.scale_factor;
    for (int i = 1; i < NumStages - 1; i++) begin
      ctx_d[i] = ctx_q[i-1];
    end
    for (int i = 0; i < NumLanes; i++) begin
      ctx_d[StSum].r[i] = lane_res[i].val;
    end
    ctx_d[StSum].rov       = lane_res[0].ov | lane_res[1].ov | lane_res[2].ov;
    ctx_d[StSum].s         = dot_sat.val;
    ctx_d[StSum].sov       = dot_sat.ov;
    ctx_d[StDivFirst].root = root;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NumStages - 1; i++) begin
        ctx_q[i] <= ctx_d[i];
      end
      out_q <= out_d;
    end
  end

  // Final selection and saturation of the quotients.
  always_comb begin
    ctx_t  c;
    sat_t  qs [NumLanes];
    logic  neg;
    c     = ctx_q[StDivLast];
    out_d = '0;
    for (int i = 0; i < NumLanes; i++) begin
      neg   = c.a[i][CompW-1] ^ ((c.func == FuncDiv) && c.k[CompW-1]);
      qs[i] = sat_wide(neg ? -SumW'({1'b0, quo[i]}) : SumW'({1'b0, quo[i]}));
    end
    unique case (c.func)
      FuncAdd, FuncSub, FuncScale, FuncCross, FuncNeg: begin
        out_d.rx       = c.r[0];
        out_d.ry       = c.r[1];
        out_d.rz       = c.r[2];
        out_d.overflow = c.rov;
      end
      FuncDot: begin
        out_d.scalar_result = c.s;
        out_d.overflow      = c.sov;
      end
      FuncLen: begin
        // The root is unsigned; its top bit set means it is above the maximum.
        out_d.scalar_result = c.root[RootW-1] ? MaxV : comp_t'(c.root);
        out_d.overflow      = c.root[RootW-1];
      end
      FuncNorm, FuncDiv: begin
        if ((c.func == FuncDiv) && (c.k == '0)) begin
          out_d.div_zero = 1'b1;
        end else if ((c.func == FuncDiv) || (c.root != '0)) begin
          out_d.rx       = qs[0].val;
          out_d.ry       = qs[1].val;
          out_d.rz       = qs[2].val;
          out_d.overflow = qs[0].ov | qs[1].ov | qs[2].ov;
        end
      end
      default: out_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      skid_full_q <= 1'b0;
    end else begin
      if (en) begin
        v_q <= {v_q[NumStages-2:0], in_valid_i};
      end
      if (!skid_full_q && v_q[Last] && out_stall_i) begin
        skid_full_q <= 1'b1;
      end else if (skid_full_q && !out_stall_i) begin
        skid_full_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_full_q && v_q[Last] && out_stall_i) begin
      skid_q <= out_q;
    end
  end

  assign out_valid_o = v_q[Last] || skid_full_q;
  assign out_data_o  = skid_full_q ? skid_q : out_q;

  // An item held in the skid buffer is always offered downstream.
  `VFA_ASSERT_ALWAYS(a_skid_offered, !skid_full_q || out_valid_o, "skid item not offered")
  // The skid buffer only fills because the consumer stalled.
  `VFA_ASSERT(a_skid_on_stall, $rose(skid_full_q) |-> $past(out_stall_i), "skid filled without stall")
  // Each normalized component is at most one in magnitude, so it cannot saturate.
  `VFA_ASSERT(a_norm_no_ov, v_q[Last-1] && (ctx_q[StDivLast].func == FuncNorm) |-> !out_d.overflow, "normalize saturated")
  // Divide by zero never reports overflow as well.
  `VFA_ASSERT(a_flags_apart, v_q[Last-1] |-> !(out_d.overflow && out_d.div_zero), "both flags set")

endmodule
